>>> src/gcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcp_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned ColW   = 8;
	localparam int unsigned DivSteps = CoordW;
	localparam int unsigned CntW   = $clog2(DivSteps);

	localparam logic [ColW-1:0]   ColumnsReset = ColW'(2);
	localparam logic [CoordW-1:0] WidthReset   = '0;

	typedef enum logic [1:0] {
		REG_COLUMNS   = 2'd0,
		REG_CONTAINER = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} gcp_state_t;

	typedef struct packed {
		logic              done;
		logic [CoordW-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> src/gcp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// signed 16-bit dividend by unsigned 8-bit divisor, one quotient bit per cycle,
// quotient truncated toward zero
module gcp_div
	import gcp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CoordW-1:0] dividend,
	input  wire logic [ColW-1:0]   divisor,
	output div_rsp_t               rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [ColW-1:0]   rem_q;
	logic [CoordW-1:0] mag_q;
	logic [ColW-1:0]   dvs_q;
	logic              neg_q;

	logic [ColW:0]     trial;
	logic [ColW:0]     diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, mag_q[CoordW-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[CoordW-1];
			mag_q <= dividend[CoordW-1] ? (~dividend + CoordW'(1)) : dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ColW-1:0] : trial[ColW-1:0];
			mag_q <= {mag_q[CoordW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (~mag_q + CoordW'(1)) : mag_q;

endmodule

`default_nettype wire

>>> src/grid_cell_placer.sv
// Grid cell placer: one box word in, zero or one position word out.
// Shown box: a serial divide for the cell width, a quotient capture, a multiply
// step and an output load lie between accept and out_valid; in_stall is high
// meanwhile, so no new box is taken until the position word is loaded, which
// waits while out_stall holds the previous position word. Hidden box or zero
// columns: taken in idle without a stall, no output word.
// Asynchronous reset: columns = 2, container_width = 0, pass state cleared.
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_placer
	import gcp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CoordW-1:0] cfg_data,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              first_of_pass,
	input  wire logic              hidden,
	input  wire logic [CoordW-1:0] box_width,
	input  wire logic [CoordW-1:0] box_height,
	input  wire logic [CoordW-1:0] margin_left,
	input  wire logic [CoordW-1:0] margin_right,
	input  wire logic [CoordW-1:0] margin_top,
	input  wire logic [CoordW-1:0] margin_bottom,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CoordW-1:0]      pos_x,
	output logic [CoordW-1:0]      pos_y
);

	gcp_state_t        state_q, state_d;

	logic [ColW-1:0]   columns_q;
	logic [CoordW-1:0] cwidth_q;

	logic [ColW-1:0]   column_now_q;
	logic              any_placed_q;
	logic [CoordW-1:0] row_top_q;
	logic [CoordW-1:0] row_tallest_q;

	logic [ColW-1:0]   col_q;
	logic [CoordW-1:0] fw_q;
	logic [CoordW-1:0] ml_q;
	logic [CoordW-1:0] y_q;
	logic [CoordW-1:0] cell_q;
	logic [CoordW-1:0] prod_q;
	logic [CoordW-1:0] half_q;

	logic              out_valid_q;
	logic [CoordW-1:0] pos_x_q;
	logic [CoordW-1:0] pos_y_q;

	logic              accept;
	logic              place;
	logic              div_start;
	logic              load_out;
	div_rsp_t          div_rsp;

	logic [ColW-1:0]   e_cn;
	logic              e_ap;
	logic [CoordW-1:0] e_rt;
	logic [CoordW-1:0] e_rtall;
	logic [ColW-1:0]   col;
	logic              new_row;
	logic [CoordW-1:0] rt_new;
	logic [CoordW-1:0] rtall_new;
	logic [CoordW-1:0] fh;
	logic [ColW:0]     col_inc;
	logic [ColW-1:0]   cn_next;
	logic [CoordW-1:0] diff;
	logic [CoordW-1:0] diff_adj;
	logic [ColW+CoordW-1:0] prod_full;

	assign cfg_ready = 1'b1;

	always_comb begin
		e_cn    = first_of_pass ? '0 : column_now_q;
		e_ap    = first_of_pass ? 1'b0 : any_placed_q;
		e_rt    = first_of_pass ? '0 : row_top_q;
		e_rtall = first_of_pass ? '0 : row_tallest_q;
		col     = (e_cn >= columns_q) ? '0 : e_cn;
		new_row = (col == '0) && e_ap;
		rt_new  = new_row ? (e_rt + e_rtall) : e_rt;
		fh      = box_height + margin_top + margin_bottom;
		rtall_new = new_row ? '0 : e_rtall;
		if ($signed(fh) > $signed(rtall_new)) begin
			rtall_new = fh;
		end
		col_inc = {1'b0, col} + (ColW+1)'(1);
		cn_next = (col_inc >= {1'b0, columns_q}) ? '0 : col_inc[ColW-1:0];

		diff      = cell_q - fw_q;
		diff_adj  = diff + {{(CoordW-1){1'b0}}, diff[CoordW-1]};
		prod_full = col_q * cell_q;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		load_out  = 1'b0;
		accept    = 1'b0;
		place     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				place    = in_valid && !hidden && (columns_q != '0);
				if (place) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= ColumnsReset;
			cwidth_q  <= WidthReset;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_COLUMNS) begin
				columns_q <= cfg_data[ColW-1:0];
			end else if (cfg_index == REG_CONTAINER) begin
				cwidth_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_now_q  <= '0;
			any_placed_q  <= 1'b0;
			row_top_q     <= '0;
			row_tallest_q <= '0;
		end else if (accept) begin
			if (place) begin
				column_now_q  <= cn_next;
				any_placed_q  <= 1'b1;
				row_top_q     <= rt_new;
				row_tallest_q <= rtall_new;
			end else begin
				column_now_q  <= e_cn;
				any_placed_q  <= e_ap;
				row_top_q     <= e_rt;
				row_tallest_q <= e_rtall;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place) begin
			col_q <= col;
			fw_q  <= box_width + margin_left + margin_right;
			ml_q  <= margin_left;
			y_q   <= rt_new + margin_top;
		end
		if (div_rsp.done) begin
			cell_q <= div_rsp.quot;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_full[CoordW-1:0];
			half_q <= {diff_adj[CoordW-1], diff_adj[CoordW-1:1]};
		end
		if (load_out) begin
			pos_x_q <= prod_q + half_q + ml_q;
			pos_y_q <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	gcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cwidth_q),
		.divisor  (columns_q),
		.rsp      (div_rsp)
	);

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;

endmodule

`default_nettype wire

>>> sim/grid_cell_placer_tb.sv
`timescale 1ns / 1ps

import gcp_pkg::*;

typedef struct packed {
	logic              first;
	logic              hidden;
	logic [CoordW-1:0] w;
	logic [CoordW-1:0] h;
	logic [CoordW-1:0] ml;
	logic [CoordW-1:0] mr;
	logic [CoordW-1:0] mt;
	logic [CoordW-1:0] mb;
} box_t;

typedef struct packed {
	logic [CoordW-1:0] x;
	logic [CoordW-1:0] y;
} pos_t;

class grid_position_board;
	logic [ColW-1:0]   columns;
	logic [CoordW-1:0] container_width;
	logic [ColW-1:0]   column_now;
	bit                any_placed;
	logic [CoordW-1:0] row_top;
	logic [CoordW-1:0] row_tallest;
	pos_t              expected_pos[$];

	function new();
		columns = ColumnsReset;
		container_width = WidthReset;
		clear_pass();
	endfunction

	function void clear_pass();
		column_now = '0;
		any_placed = 0;
		row_top = '0;
		row_tallest = '0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [CoordW-1:0] data);
		case (idx)
			REG_COLUMNS: begin
				columns = data[ColW-1:0];
			end
			REG_CONTAINER: begin
				container_width = data;
			end
			default: begin
			end
		endcase
	endfunction

	function int unsigned outstanding();
		return expected_pos.size();
	endfunction

	function void place_box(box_t b);
		logic [ColW-1:0]          col;
		logic [CoordW-1:0]        cell_w, fw, fh, half;
		logic signed [CoordW-1:0] gap;
		int                       cw_s, cols_i, quo, gap_i;
		pos_t                     p;
		if (b.first)
			clear_pass();
		if (b.hidden || columns == 0)
			return;
		col = column_now;
		if (col >= columns)
			col = '0;
		if (col == 0 && any_placed) begin
			row_top = row_top + row_tallest;
			row_tallest = '0;
		end
		cw_s = $signed(container_width);
		cols_i = columns;
		quo = cw_s / cols_i;
		cell_w = quo[CoordW-1:0];
		fw = b.w + b.ml + b.mr;
		fh = b.h + b.mt + b.mb;
		gap = cell_w - fw;
		gap_i = gap;
		gap_i = gap_i / 2;
		half = gap_i[CoordW-1:0];
		p.x = col * cell_w + half + b.ml;
		p.y = row_top + b.mt;
		if ($signed(fh) > $signed(row_tallest))
			row_tallest = fh;
		col = col + 1'b1;
		if (col >= columns)
			col = '0;
		column_now = col;
		any_placed = 1;
		expected_pos.push_back(p);
	endfunction

	function string check_pos(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
		pos_t  want;
		string why;
		why = "";
		if (expected_pos.size() == 0)
			return $sformatf("position word (%0d,%0d) with none pending",
				$signed(x), $signed(y));
		want = expected_pos.pop_front();
		if (x !== want.x)
			why = {why, $sformatf(" pos_x %0d want %0d", $signed(x), $signed(want.x))};
		if (y !== want.y)
			why = {why, $sformatf(" pos_y %0d want %0d", $signed(y), $signed(want.y))};
		return why;
	endfunction
endclass

module grid_cell_placer_tb;

	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PRINT_CAP     = 100;
	localparam int PER_MODE      = 334;
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [CoordW-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              first_of_pass = 1'b0;
	logic              hidden = 1'b0;
	logic [CoordW-1:0] box_width = '0;
	logic [CoordW-1:0] box_height = '0;
	logic [CoordW-1:0] margin_left = '0;
	logic [CoordW-1:0] margin_right = '0;
	logic [CoordW-1:0] margin_top = '0;
	logic [CoordW-1:0] margin_bottom = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CoordW-1:0] pos_x;
	logic [CoordW-1:0] pos_y;

	grid_position_board board = new();
	int                errors = 0;
	int                quiet_cycles = 0;
	int                send_idle_pct = 9;
	int                stall_pct = 76;

	grid_cell_placer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_of_pass(first_of_pass),
		.hidden       (hidden),
		.box_width    (box_width),
		.box_height   (box_height),
		.margin_left  (margin_left),
		.margin_right (margin_right),
		.margin_top   (margin_top),
		.margin_bottom(margin_bottom),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report(string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("MISMATCH at %0t:%s", $realtime, msg);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : pos_monitor
		string note;
		if (arst_n && out_valid && !out_stall) begin
			note = board.check_pos(pos_x, pos_y);
			if (note != "")
				report(note);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// all driving tasks start and end at a falling edge
	task automatic send_box(box_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		first_of_pass <= b.first;
		hidden        <= b.hidden;
		box_width     <= b.w;
		box_height    <= b.h;
		margin_left   <= b.ml;
		margin_right  <= b.mr;
		margin_top    <= b.mt;
		margin_bottom <= b.mb;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.place_box(b);
		@(negedge clk);
	endtask

	task automatic send_fields(logic f, logic hd, logic [CoordW-1:0] w, logic [CoordW-1:0] h,
		logic [CoordW-1:0] ml, logic [CoordW-1:0] mr, logic [CoordW-1:0] mt,
		logic [CoordW-1:0] mb);
		box_t b;
		b = '{first: f, hidden: hd, w: w, h: h, ml: ml, mr: mr, mt: mt, mb: mb};
		send_box(b);
	endtask

	task automatic program_reg(logic [1:0] idx, logic [CoordW-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// hold off input until every pending position word is out, then let the block settle
	task automatic drain_placements();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (board.outstanding() != 0 && waited < QUIET_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CoordW-1:0] pick_coord();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(320)) - 16'd20;
		endcase
	endfunction

	function automatic logic [ColW-1:0] pick_columns();
		case ($urandom_range(11))
			0: return '0;
			1: return 8'hff;
			2: return 8'd1;
			3: return 8'($urandom_range(254, 5));
			default: return 8'($urandom_range(6, 2));
		endcase
	endfunction

	function automatic logic [CoordW-1:0] pick_width();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom);
			3: return '0;
			default: return 16'($urandom_range(1500, 50));
		endcase
	endfunction

	function automatic box_t random_box();
		box_t b;
		b.first  = 1'b0;
		b.hidden = ($urandom_range(6) == 0);
		b.w  = pick_coord();
		b.h  = pick_coord();
		b.ml = pick_coord();
		b.mr = pick_coord();
		b.mt = pick_coord();
		b.mb = pick_coord();
		return b;
	endfunction

	initial begin
		box_t b;
		int   sent, budget, run_len, waited;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: two columns, zero width
		send_fields(1'b1, 1'b0, 16'd10, 16'd10, 16'd0, 16'd0, 16'd0, 16'd0);
		send_fields(1'b0, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_fields(1'b0, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_fields(1'b0, 1'b1, 16'd5, 16'd5, 16'd1, 16'd1, 16'd1, 16'd1);
		send_fields(1'b1, 1'b1, 16'd7, 16'd7, 16'd2, 16'd2, 16'd2, 16'd2);
		send_fields(1'b0, 1'b0, 16'd20, 16'd30, 16'd1, 16'd2, 16'd3, 16'd4);
		drain_placements();
		program_reg(REG_COLUMNS, 16'd3);
		program_reg(REG_CONTAINER, 16'h7fff);
		send_fields(1'b1, 1'b0, 16'd100, 16'd40, 16'd5, 16'd5, 16'd2, 16'd2);
		send_fields(1'b0, 1'b0, -16'sd30, -16'sd10, -16'sd4, 16'd3, -16'sd2, -16'sd1);
		send_fields(1'b0, 1'b0, 16'd50, 16'd60, 16'd0, 16'd0, 16'd0, 16'd0);
		send_fields(1'b0, 1'b0, 16'd80, 16'd20, 16'd1, 16'd1, 16'd1, 16'd1);
		send_fields(1'b0, 1'b0, 16'd80, 16'd20, 16'd1, 16'd1, 16'd1, 16'd1);
		// column count lowered mid-pass
		drain_placements();
		program_reg(REG_COLUMNS, 16'd1);
		send_fields(1'b0, 1'b0, 16'd10, 16'd15, 16'd2, 16'd2, 16'd2, 16'd2);
		send_fields(1'b0, 1'b0, 16'd10, 16'd15, 16'd2, 16'd2, 16'd2, 16'd2);
		drain_placements();
		program_reg(REG_COLUMNS, 16'd0);
		send_fields(1'b0, 1'b0, 16'd10, 16'd10, 16'd1, 16'd1, 16'd1, 16'd1);
		send_fields(1'b1, 1'b0, 16'd10, 16'd10, 16'd1, 16'd1, 16'd1, 16'd1);
		drain_placements();
		program_reg(REG_COLUMNS, 16'd255);
		program_reg(REG_CONTAINER, 16'h8000);
		send_fields(1'b1, 1'b0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_fields(1'b0, 1'b0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_fields(1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		drain_placements();
		program_reg(REG_SPARE_LO, 16'hffff);
		program_reg(REG_SPARE_HI, 16'h0000);
		send_fields(1'b0, 1'b0, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3);

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 9;
					stall_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					stall_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < PER_MODE) begin
				drain_placements();
				program_reg(REG_COLUMNS, {8'h00, pick_columns()});
				program_reg(REG_CONTAINER, pick_width());
				if ($urandom_range(7) == 0)
					program_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
						16'($urandom));
				budget = $urandom_range(120, 60);
				while (budget > 0 && sent < PER_MODE) begin
					run_len = $urandom_range(10, 1);
					for (int i = 0; i < run_len && budget > 0; i++) begin
						b = random_box();
						b.first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
						send_box(b);
						budget--;
						sent++;
					end
				end
			end
		end

		in_valid <= 1'b0;
		waited = 0;
		while (board.outstanding() != 0 && waited < QUIET_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (board.outstanding() != 0)
			report($sformatf(" %0d position words never arrived", board.outstanding()));
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
src/gcp_pkg.sv
src/gcp_div.sv
src/grid_cell_placer.sv
sim/grid_cell_placer_tb.sv
